// File: rtl/sfd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared constants, result type and CRC-16 byte update for the short frame
// deframer.
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam logic [7:0]  START_BYTE  = 8'd2;
  localparam logic [7:0]  STOP_BYTE   = 8'd3;
  localparam logic [7:0]  CMD_RESET   = 8'd4;
  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [15:0] CRC_INIT    = 16'h0000;

  typedef enum logic [1:0] {
    STAT_GOOD     = 2'd0,
    STAT_CRC_ERR  = 2'd1,
    STAT_STOP_ERR = 2'd2
  } sfd_status_e;

  typedef struct packed {
    logic        is_frame_end;
    logic [7:0]  data_byte;
    logic        first_of_payload;
    sfd_status_e frame_status;
    logic        command_ok;
    logic [7:0]  frame_length;
  } sfd_result_t;

  // CRC-16, polynomial 0x1021, MSB first, one byte per call.
  function automatic logic [15:0] crc16_add_byte(input logic [15:0] crc,
                                                 input logic [7:0]  b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// File: rtl/sfd_in_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_in_reg
// Input register: holds one received byte until the parser consumes it.
// ----------------------------------------------------------------------------
module sfd_in_reg import sfd_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] rx_byte_i,
  input  wire logic       can_advance_i,
  output logic            byte_valid_o,
  output logic [7:0]      byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       consume;
  logic       accept;

  assign consume    = valid_q && can_advance_i;
  assign in_ready_o = !valid_q || can_advance_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (consume) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= rx_byte_i;
    end
  end

  assign byte_valid_o = consume;
  assign byte_o       = byte_q;

endmodule
`default_nettype wire

// File: rtl/sfd_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_parser
// Frame state machine with running CRC; one byte per cycle.
// ----------------------------------------------------------------------------
module sfd_parser import sfd_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_data_i,
  input  wire logic       byte_valid_i,
  input  wire logic [7:0] byte_i,
  output logic            res_valid_o,
  output sfd_result_t     res_o
);

  localparam logic [2:0] PH_HUNT   = 3'd0;
  localparam logic [2:0] PH_LEN    = 3'd1;
  localparam logic [2:0] PH_DATA   = 3'd2;
  localparam logic [2:0] PH_CRC_HI = 3'd3;
  localparam logic [2:0] PH_CRC_LO = 3'd4;
  localparam logic [2:0] PH_STOP   = 3'd5;

  logic [2:0]  phase_q, phase_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  left_q, left_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] rx_crc_q, rx_crc_d;
  logic        match_q, match_d;
  logic        first;
  sfd_status_e status;

  assign first = (left_q == len_q);

  always_comb begin
    if (byte_i != STOP_BYTE) begin
      status = STAT_STOP_ERR;
    end else if (rx_crc_q != crc_q) begin
      status = STAT_CRC_ERR;
    end else begin
      status = STAT_GOOD;
    end
  end

  always_comb begin
    phase_d     = phase_q;
    cmd_d       = cfg_we_i ? cfg_data_i : cmd_q;
    len_d       = len_q;
    left_d      = left_q;
    crc_d       = crc_q;
    rx_crc_d    = rx_crc_q;
    match_d     = match_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (byte_valid_i) begin
      unique case (phase_q)
        PH_HUNT: begin
          if (byte_i == START_BYTE) begin
            phase_d = PH_LEN;
          end
        end
        PH_LEN: begin
          len_d    = byte_i;
          left_d   = byte_i;
          crc_d    = CRC_INIT;
          rx_crc_d = 16'h0000;
          match_d  = 1'b0;
          phase_d  = (byte_i == 8'd0) ? PH_CRC_HI : PH_DATA;
        end
        PH_DATA: begin
          if (first) begin
            match_d = (byte_i == cmd_q);
          end
          crc_d  = crc16_add_byte(crc_q, byte_i);
          left_d = left_q - 8'd1;
          if (left_q == 8'd1) begin
            phase_d = PH_CRC_HI;
          end
          res_valid_o            = 1'b1;
          res_o.data_byte        = byte_i;
          res_o.first_of_payload = first;
        end
        PH_CRC_HI: begin
          rx_crc_d = {byte_i, 8'h00};
          phase_d  = PH_CRC_LO;
        end
        PH_CRC_LO: begin
          rx_crc_d = {rx_crc_q[15:8], byte_i};
          phase_d  = PH_STOP;
        end
        PH_STOP: begin
          res_valid_o        = 1'b1;
          res_o.is_frame_end = 1'b1;
          res_o.frame_status = status;
          res_o.command_ok   = (len_q != 8'd0) && match_q;
          res_o.frame_length = len_q;
          phase_d            = PH_HUNT;
        end
        default: begin
          phase_d = PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT;
      cmd_q    <= CMD_RESET;
      len_q    <= 8'd0;
      left_q   <= 8'd0;
      crc_q    <= CRC_INIT;
      rx_crc_q <= 16'h0000;
      match_q  <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      cmd_q    <= cmd_d;
      len_q    <= len_d;
      left_q   <= left_d;
      crc_q    <= crc_d;
      rx_crc_q <= rx_crc_d;
      match_q  <= match_d;
    end
  end

  a_res_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (phase_q == PH_DATA || phase_q == PH_STOP))
    else $error("result outside data or stop phase");

  a_stop_to_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (byte_valid_i && phase_q == PH_STOP) |=> (phase_q == PH_HUNT))
    else $error("stop byte did not return to hunting");

  a_data_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA) |-> (left_q != 8'd0))
    else $error("data phase with no bytes left");

  a_zero_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (byte_valid_i && phase_q == PH_LEN && byte_i == 8'd0) |=> (phase_q == PH_CRC_HI))
    else $error("zero-length frame did not skip to CRC");

endmodule
`default_nettype wire

// File: rtl/sfd_out_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_out_reg
// Result register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module sfd_out_reg import sfd_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         load_i,
  input  wire sfd_result_t  res_i,
  output logic              can_load_o,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output sfd_result_t       res_o
);

  logic        valid_q, valid_d;
  sfd_result_t res_q;

  assign can_load_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule
`default_nettype wire

// File: rtl/short_frame_deframer_crc16_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// short_frame_deframer_crc16_top
// Link byte deframer: start byte, length, payload with CRC-16, CRC, stop.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o, rx_byte_i) takes one link byte
//   per transfer. Output channel (out_valid_o / out_ready_i) carries one
//   result per payload byte and one frame-end result per byte in the stop
//   position; start, length, CRC and hunted bytes give no result.
//   Configuration channel (cfg_valid_i / cfg_ready_o, cfg_data_i) writes the
//   expected command code; it is always ready. Write it only while idle.
// Timing:
//   A byte sits in the input register after its transfer and is parsed into
//   the result register once that register can load; out_valid_o rises
//   when a result is registered there, and the result transfers on a cycle
//   with out_ready_i high. Throughput is one byte per cycle while the receiver
//   keeps up, as the byte-parallel CRC update between the registers allows.
// Reset:
//   rst_ni clears both registers' valid flags, returns the parser to
//   hunting for the start byte and loads the expected command with 4.
// Back-pressure:
//   While the receiver stalls with a result pending, hold the next byte in
//   the input register; in_ready_o drops once that register is full too.
// ----------------------------------------------------------------------------
module short_frame_deframer_crc16_top import sfd_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [7:0] cfg_data_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] rx_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic            is_frame_end_o,
  output logic [7:0]      data_byte_o,
  output logic            first_of_payload_o,
  output logic [1:0]      frame_status_o,
  output logic            command_ok_o,
  output logic [7:0]      frame_length_o
);

  logic        can_advance;
  logic        byte_valid;
  logic [7:0]  byte_val;
  logic        res_valid;
  sfd_result_t res;
  sfd_result_t out_res;

  // configuration writes are always accepted
  assign cfg_ready_o = 1'b1;

  sfd_in_reg u_in_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .rx_byte_i     (rx_byte_i),
    .can_advance_i (can_advance),
    .byte_valid_o  (byte_valid),
    .byte_o        (byte_val)
  );

  sfd_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .byte_valid_i (byte_valid),
    .byte_i       (byte_val),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  // advance a byte only when its possible result has a free slot
  sfd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .res_i       (res),
    .can_load_o  (can_advance),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (out_res)
  );

  assign is_frame_end_o     = out_res.is_frame_end;
  assign data_byte_o        = out_res.data_byte;
  assign first_of_payload_o = out_res.first_of_payload;
  assign frame_status_o     = out_res.frame_status;
  assign command_ok_o       = out_res.command_ok;
  assign frame_length_o     = out_res.frame_length;

endmodule
`default_nettype wire

// File: sim/short_frame_deframer_crc16_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// short_frame_deframer_crc16_top_tb
// Self-checking bench for the short frame deframer. Feed link bytes through
// a bursty valid/ready sender and predict every payload and frame-end result
// with a byte-level parser model. Compare each result against the oldest
// prediction while the receiver stalls on its own pattern. Rewrite the
// expected command between phases, once the block has gone quiet.
// ----------------------------------------------------------------------------
module short_frame_deframer_crc16_top_tb import sfd_pkg::*; ();

  localparam int CLK_PERIOD    = 4;
  localparam int SETTLE_CYCLES = 6;       // two register stages plus margin
  localparam int CYCLE_LIMIT   = 500000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_BYTES   = 90;

  typedef enum logic [2:0] {
    PS_HUNT,
    PS_LEN,
    PS_DATA,
    PS_CRC_HI,
    PS_CRC_LO,
    PS_STOP
  } parse_state_e;

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_PERIODIC,
    RDY_BURSTY
  } ready_mode_e;

  // DUT-facing signals; every input starts at a known value.
  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [7:0] cfg_data_i  = 8'h00;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  logic [7:0] rx_byte_i   = 8'h00;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic       is_frame_end_o;
  logic [7:0] data_byte_o;
  logic       first_of_payload_o;
  logic [1:0] frame_status_o;
  logic       command_ok_o;
  logic [7:0] frame_length_o;

  // Link bytes waiting to go out, and results the parser model has promised.
  logic [7:0]  link_bytes[$];
  sfd_result_t pending_results[$];
  sfd_result_t want_result;

  // Parser model state, advanced once per accepted byte.
  parse_state_e parse_state   = PS_HUNT;
  logic [7:0]   hdr_length    = 8'h00;
  logic [7:0]   bytes_left    = 8'h00;
  logic [15:0]  calc_crc      = CRC_INIT;
  logic [15:0]  rx_crc        = 16'h0000;
  logic         cmd_match     = 1'b0;
  logic [7:0]   cmd_at_parser = CMD_RESET;

  // Command code as the stimulus side sees it.
  logic [7:0] cmd_setting = CMD_RESET;

  // Sender burst shaping.
  int burst_left = 0;
  int gap_left   = 0;

  // Receiver stall pattern.
  ready_mode_e ready_mode   = RDY_ALWAYS;
  int          mode_left    = 0;
  int          ready_period = 2;
  int          ready_tick   = 0;
  int          stall_left   = 0;

  int cycle_count     = 0;
  int error_count     = 0;
  int bytes_in        = 0;
  int payload_seen    = 0;
  int cfg_writes      = 0;
  int queued_in_phase = 0;
  int ends_by_status[3] = '{0, 0, 0};

  short_frame_deframer_crc16_top uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .rx_byte_i          (rx_byte_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .is_frame_end_o     (is_frame_end_o),
    .data_byte_o        (data_byte_o),
    .first_of_payload_o (first_of_payload_o),
    .frame_status_o     (frame_status_o),
    .command_ok_o       (command_ok_o),
    .frame_length_o     (frame_length_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // CRC-16/XMODEM, one data bit at a time: feed back the XOR of the CRC's
  // top bit and the incoming bit.
  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    int          i;
    c = crc;
    for (i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

  // Advance the parser model by one link byte and queue the result it causes.
  task automatic advance_parser(input logic [7:0] b);
    sfd_result_t r;
    logic        first;
    r = '0;
    r.frame_status = STAT_GOOD;
    case (parse_state)
      PS_HUNT: begin
        if (b == START_BYTE) parse_state = PS_LEN;
      end
      PS_LEN: begin
        hdr_length  = b;
        bytes_left  = b;
        calc_crc    = CRC_INIT;
        rx_crc      = 16'h0000;
        cmd_match   = 1'b0;
        parse_state = (b == 8'h00) ? PS_CRC_HI : PS_DATA;
      end
      PS_DATA: begin
        // Decide the command match on the first byte, with the register as
        // it stands right now.
        first = (bytes_left == hdr_length);
        if (first) cmd_match = (b == cmd_at_parser);
        calc_crc   = crc16_step(calc_crc, b);
        bytes_left = bytes_left - 8'd1;
        if (bytes_left == 8'h00) parse_state = PS_CRC_HI;
        r.data_byte        = b;
        r.first_of_payload = first;
        pending_results.push_back(r);
      end
      PS_CRC_HI: begin
        rx_crc      = {b, 8'h00};
        parse_state = PS_CRC_LO;
      end
      PS_CRC_LO: begin
        rx_crc[7:0] = b;
        parse_state = PS_STOP;
      end
      default: begin
        // A wrong stop byte wins over any CRC verdict.
        if (b != STOP_BYTE)        r.frame_status = STAT_STOP_ERR;
        else if (rx_crc != calc_crc) r.frame_status = STAT_CRC_ERR;
        r.is_frame_end = 1'b1;
        r.command_ok   = (hdr_length != 8'h00) && cmd_match;
        r.frame_length = hdr_length;
        pending_results.push_back(r);
        parse_state = PS_HUNT;
      end
    endcase
  endtask

  // Sender: hold the byte until it transfers, then advance through the
  // queue in bursts of random length separated by random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) cmd_at_parser = cfg_data_i;
      if (in_valid_i && in_ready_o) begin
        advance_parser(rx_byte_i);
        bytes_in++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (link_bytes.size() != 0) begin
          rx_byte_i  <= link_bytes.pop_front();
          in_valid_i <= 1'b1;
          if (burst_left != 0) begin
            burst_left--;
          end else begin
            // A third of the bursts run straight into the next one.
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each transfer against the oldest prediction, then pick
  // the next ready level from the current stall pattern.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $error("result with no prediction pending: frame_end=%0d data=%0d",
                 is_frame_end_o, data_byte_o);
          error_count++;
        end else begin
          want_result = pending_results.pop_front();
          if (is_frame_end_o !== want_result.is_frame_end) begin
            $error("is_frame_end: expected %0d, got %0d",
                   want_result.is_frame_end, is_frame_end_o);
            error_count++;
          end
          if (data_byte_o !== want_result.data_byte) begin
            $error("data_byte: expected %0d, got %0d", want_result.data_byte, data_byte_o);
            error_count++;
          end
          if (first_of_payload_o !== want_result.first_of_payload) begin
            $error("first_of_payload: expected %0d, got %0d",
                   want_result.first_of_payload, first_of_payload_o);
            error_count++;
          end
          if (frame_status_o !== want_result.frame_status) begin
            $error("frame_status: expected %0d, got %0d",
                   want_result.frame_status, frame_status_o);
            error_count++;
          end
          if (command_ok_o !== want_result.command_ok) begin
            $error("command_ok: expected %0d, got %0d", want_result.command_ok, command_ok_o);
            error_count++;
          end
          if (frame_length_o !== want_result.frame_length) begin
            $error("frame_length: expected %0d, got %0d",
                   want_result.frame_length, frame_length_o);
            error_count++;
          end
          if (want_result.is_frame_end) ends_by_status[want_result.frame_status]++;
          else payload_seen++;
        end
      end

      if (mode_left == 0) begin
        ready_mode   = ready_mode_e'($urandom_range(0, 3));
        mode_left    = $urandom_range(64, 200);
        ready_period = $urandom_range(2, 5);
      end else begin
        mode_left--;
      end
      ready_tick++;
      case (ready_mode)
        RDY_ALWAYS:   out_ready_i <= 1'b1;
        RDY_COIN:     out_ready_i <= ($urandom_range(0, 3) != 0);
        RDY_PERIODIC: out_ready_i <= (ready_tick % ready_period == 0);
        default: begin
          // Long stalls broken by short ready windows.
          if (stall_left != 0) begin
            stall_left--;
            out_ready_i <= 1'b0;
          end else begin
            out_ready_i <= 1'b1;
            if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 12);
          end
        end
      endcase
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still pending",
               cycle_count, pending_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic queue_byte(input logic [7:0] b);
    link_bytes.push_back(b);
    queued_in_phase++;
  endtask

  // Queue one frame. A first byte of -1 means random; a bad CRC flips at
  // least one bit; a bad stop is any byte but the stop code.
  task automatic push_frame(input int len, input int first, input bit crc_ok,
                            input bit stop_ok, input bit with_header);
    logic [15:0] crc;
    logic [7:0]  b;
    int          i;
    crc = CRC_INIT;
    if (with_header) begin
      queue_byte(START_BYTE);
      queue_byte(len[7:0]);
    end
    for (i = 0; i < len; i++) begin
      b = 8'($urandom_range(0, 255));
      if (i == 0 && first >= 0) b = first[7:0];
      crc = crc16_step(crc, b);
      queue_byte(b);
    end
    if (!crc_ok) crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
    queue_byte(crc[15:8]);
    queue_byte(crc[7:0]);
    if (stop_ok) begin
      queue_byte(STOP_BYTE);
    end else begin
      b = 8'($urandom_range(0, 255));
      if (b == STOP_BYTE) b = ~b;
      queue_byte(b);
    end
  endtask

  // Drain: wait for the queue, the channel and the predictions to empty,
  // then let the trailing no-result bytes clear the pipeline.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (link_bytes.size() != 0 || in_valid_i || pending_results.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_command(input logic [7:0] v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cmd_setting = v;
    cfg_writes++;
  endtask

  initial begin
    int p;
    int r;
    int len;
    logic [7:0] v;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part, with the command still at its reset value:
    // hunted noise at both byte extremes, an empty frame, a one-byte
    // command hit, an all-ones byte with a broken CRC, and a wrong stop
    // byte on top of a broken CRC.
    queue_byte(8'h00);
    queue_byte(8'hFF);
    push_frame(0, -1, 1'b1, 1'b1, 1'b1);
    push_frame(1, int'(CMD_RESET), 1'b1, 1'b1, 1'b1);
    push_frame(1, 255, 1'b0, 1'b1, 1'b1);
    push_frame(1, 0, 1'b0, 1'b0, 1'b1);

    // Stop after a header, change the command, then deliver the payload:
    // the match must use the value written mid-frame.
    queue_byte(START_BYTE);
    queue_byte(8'd1);
    wait_idle();
    v = 8'($urandom_range(0, 255));
    write_command(v);
    @(negedge clk_i);
    push_frame(1, int'(v), 1'b1, 1'b1, 1'b0);

    // Random phases: mostly well-formed frames with random content, some
    // hunted noise and cut-off headers, a full-length frame now and then.
    for (p = 0; p < RANDOM_PHASES; p++) begin
      wait_idle();
      v = (p == 0) ? 8'h00 : (p == 1) ? 8'hFF : (p == 2) ? CMD_RESET :
          8'($urandom_range(0, 255));
      write_command(v);
      @(negedge clk_i);
      queued_in_phase = 0;
      while (queued_in_phase < PHASE_BYTES) begin
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 3)) queue_byte(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 19) == 0) begin
          queue_byte(START_BYTE);
          queue_byte(8'($urandom_range(1, 8)));
        end
        r   = $urandom_range(0, 19);
        len = (r == 0) ? 0 : (r < 15) ? $urandom_range(1, 8) : $urandom_range(9, 40);
        push_frame(len, ($urandom_range(0, 1) != 0) ? int'(cmd_setting) : -1,
                   $urandom_range(0, 4) != 0, $urandom_range(0, 6) != 0, 1'b1);
      end
      if (p == 2 || p == 5) push_frame(255, int'(cmd_setting), 1'b1, 1'b1, 1'b1);
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    $display("Run covered %0d link bytes over %0d command settings and %0d payload results",
             bytes_in, cfg_writes + 1, payload_seen);
    $display("Frame ends checked: %0d good, %0d CRC mismatch, %0d bad stop byte",
             ends_by_status[STAT_GOOD], ends_by_status[STAT_CRC_ERR],
             ends_by_status[STAT_STOP_ERR]);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: short_frame_deframer_crc16_top.f
rtl/sfd_pkg.sv
rtl/sfd_in_reg.sv
rtl/sfd_parser.sv
rtl/sfd_out_reg.sv
rtl/short_frame_deframer_crc16_top.sv
sim/short_frame_deframer_crc16_top_tb.sv
